// ===== hdl/spectrum_bin_smooth_peak_hold_unit_macros.svh =====
// Assertion macros used by the back end (sbsph_back) of the spectrum bin smoothing unit.
`ifndef SPECTRUM_BIN_SMOOTH_PEAK_HOLD_UNIT_MACROS_SVH
`define SPECTRUM_BIN_SMOOTH_PEAK_HOLD_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SBSPH_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SBSPH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/sbsph_pkg.sv =====
`timescale 1ns / 1ps

package sbsph_pkg;

   localparam int NUM_BINS    = 512;
   localparam int ADDR_W      = $clog2(NUM_BINS);
   localparam int BIN_W       = 9;
   localparam int LEVEL_W     = 16;
   localparam int FACTOR_W    = 17;
   localparam int DECAY_W     = 10;
   localparam int HOLD_W      = 9;
   localparam int COEFF_W     = 16;
   localparam int Q_SHIFT     = 16;
   localparam int CSR_ADDR_W  = 4;
   localparam int CSR_DATA_W  = 32;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam logic signed [LEVEL_W-1:0] FLOOR_DB    = -16'sd25600;
   localparam logic [FACTOR_W-1:0]       ONE_Q16     = 17'd65536;
   localparam logic [FACTOR_W-1:0]       BYPASS_MAX  = 17'd655;
   localparam logic [COEFF_W-1:0]        COEFF_SCALE = 16'd62259;

   localparam logic [FACTOR_W-1:0] FACTOR_RESET = 17'd0;
   localparam logic [DECAY_W-1:0]  DECAY_RESET  = 10'd85;
   localparam logic [HOLD_W-1:0]   HOLD_RESET   = 9'd60;
   localparam logic                ENABLE_RESET = 1'b1;

   typedef enum logic [1:0] {
      REG_SMOOTHING_FACTOR = 2'd0,
      REG_DECAY_PER_FRAME  = 2'd1,
      REG_HOLD_FRAMES      = 2'd2,
      REG_PEAK_HOLD_ENABLE = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic                      in_range;
      logic [BIN_W-1:0]          bin;
      logic signed [LEVEL_W-1:0] level;
   } queue_entry_type;

   typedef struct packed {
      logic [COEFF_W-1:0] coeff;
      logic               bypass;
      logic [DECAY_W-1:0] decay;
      logic [HOLD_W-1:0]  hold;
      logic               peak_enable;
   } config_type;

   typedef struct packed {
      logic signed [LEVEL_W-1:0] smoothed;
      logic signed [LEVEL_W-1:0] peak;
      logic [HOLD_W-1:0]         hold_count;
   } store_word_type;

   localparam int WORD_W = $bits(store_word_type);

endpackage

// ===== hdl/sbsph_ram.sv =====
`timescale 1ns / 1ps

module sbsph_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Read returns the old contents when the same entry is written in the same cycle.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== hdl/sbsph_csr.sv =====
`timescale 1ns / 1ps

module sbsph_csr
   import sbsph_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output config_type            cfg
);

   logic [FACTOR_W-1:0] factor_ff, factor_in;
   logic [DECAY_W-1:0]  decay_ff, decay_in;
   logic [HOLD_W-1:0]   hold_ff, hold_in;
   logic                enable_ff, enable_in;
   logic [COEFF_W-1:0]  coeff_ff, coeff_in;
   logic                bypass_ff, bypass_in;

   logic                        wr_en;
   reg_index_type               index;
   logic [FACTOR_W-1:0]         factor_sat;
   logic [FACTOR_W+COEFF_W-1:0] coeff_prod;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;
   assign index  = reg_index_type'(paddr[3:2]);

   always_comb begin
      factor_in = factor_ff;
      decay_in  = decay_ff;
      hold_in   = hold_ff;
      enable_in = enable_ff;
      if (wr_en) begin
         unique case (index)
            REG_SMOOTHING_FACTOR: factor_in = pwdata[FACTOR_W-1:0];
            REG_DECAY_PER_FRAME:  decay_in  = pwdata[DECAY_W-1:0];
            REG_HOLD_FRAMES:      hold_in   = pwdata[HOLD_W-1:0];
            REG_PEAK_HOLD_ENABLE: enable_in = pwdata[0];
            default: ;
         endcase
      end
   end

   // A factor above one acts as one; the coefficient is 0.95 of it in Q0.16.
   always_comb begin
      factor_sat = (factor_ff > ONE_Q16) ? ONE_Q16 : factor_ff;
      coeff_prod = (FACTOR_W+COEFF_W)'(factor_sat) * (FACTOR_W+COEFF_W)'(COEFF_SCALE);
      coeff_in   = coeff_prod[Q_SHIFT +: COEFF_W];
      bypass_in  = (factor_sat <= BYPASS_MAX);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         factor_ff <= FACTOR_RESET;
         decay_ff  <= DECAY_RESET;
         hold_ff   <= HOLD_RESET;
         enable_ff <= ENABLE_RESET;
         coeff_ff  <= '0;
         bypass_ff <= 1'b1;
      end else begin
         factor_ff <= factor_in;
         decay_ff  <= decay_in;
         hold_ff   <= hold_in;
         enable_ff <= enable_in;
         coeff_ff  <= coeff_in;
         bypass_ff <= bypass_in;
      end
   end

   always_comb begin
      unique case (index)
         REG_SMOOTHING_FACTOR: prdata = CSR_DATA_W'(factor_ff);
         REG_DECAY_PER_FRAME:  prdata = CSR_DATA_W'(decay_ff);
         REG_HOLD_FRAMES:      prdata = CSR_DATA_W'(hold_ff);
         REG_PEAK_HOLD_ENABLE: prdata = CSR_DATA_W'(enable_ff);
         default:              prdata = '0;
      endcase
   end

   assign cfg = '{coeff: coeff_ff, bypass: bypass_ff, decay: decay_ff,
                  hold: hold_ff, peak_enable: enable_ff};

endmodule

// ===== hdl/sbsph_front.sv =====
`timescale 1ns / 1ps

module sbsph_front
   import sbsph_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [BIN_W-1:0]          req_bin_index,
   input  logic signed [LEVEL_W-1:0] req_level_db,
   input  logic                      clearing,
   output logic                      q_valid,
   output queue_entry_type           q_entry,
   input  logic                      q_pop
);

   queue_entry_type   mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;

   logic            push;
   queue_entry_type entry;

   // Requests for bins past the end of the store are marked here so the back end
   // skips the store update for them.
   assign entry.in_range = (32'(req_bin_index) < 32'(NUM_BINS));
   assign entry.bin      = req_bin_index;
   assign entry.level    = req_level_db;

   assign req_ready = (count_ff != (QPTR_W+1)'(QUEUE_DEPTH)) && !clearing;
   assign push      = req_valid && req_ready;
   assign q_valid   = (count_ff != '0);
   assign q_entry   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push  ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = q_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (QPTR_W+1)'(push) - (QPTR_W+1)'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= entry;
      end
   end

endmodule

// ===== hdl/sbsph_back.sv =====
`timescale 1ns / 1ps
`include "spectrum_bin_smooth_peak_hold_unit_macros.svh"

module sbsph_back
   import sbsph_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  config_type                cfg,
   input  logic                      q_valid,
   input  queue_entry_type           q_entry,
   output logic                      q_pop,
   output logic                      clearing,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [BIN_W-1:0]          rsp_out_bin,
   output logic signed [LEVEL_W-1:0] rsp_smoothed_db,
   output logic signed [LEVEL_W-1:0] rsp_peak_db
);

   localparam int PROD_W     = 2 * (LEVEL_W + 1);
   localparam int ROUND_BIAS = (1 << Q_SHIFT) - 1;
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NUM_BINS - 1);

   // Clearing sweep over the store after reset.
   logic              clearing_ff, clearing_in;
   logic [ADDR_W-1:0] clr_cnt_ff, clr_cnt_in;

   // Execute stage.
   logic            e_valid_ff, e_valid_in;
   queue_entry_type e_entry_ff;

   // Last store update, forwarded to a following request for the same bin.
   logic             fwd_valid_ff, fwd_valid_in;
   logic [BIN_W-1:0] fwd_bin_ff;
   store_word_type   fwd_word_ff;

   // Result register.
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [BIN_W-1:0]          rsp_bin_ff;
   logic signed [LEVEL_W-1:0] rsp_sm_ff;
   logic signed [LEVEL_W-1:0] rsp_pk_ff;

   logic                      out_free, e_fire, e_advance, e_update;
   logic [WORD_W-1:0]         ram_rdata, ram_wdata;
   logic                      ram_we;
   logic [ADDR_W-1:0]         ram_waddr;
   store_word_type            old_word, new_word;
   logic signed [LEVEL_W-1:0] lvl, old_sm, old_pk, sm_blend, sm_new, pk_new, pk_clamped;
   logic signed [LEVEL_W:0]   diff, coeff_s, pk_dec, sm_ext;
   logic signed [PROD_W-1:0]  prod, adj, shifted;
   logic [HOLD_W-1:0]         hc_new;
   logic signed [LEVEL_W-1:0] out_sm, out_pk;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign e_fire    = e_valid_ff && out_free;
   assign e_advance = !e_valid_ff || e_fire;
   assign q_pop     = q_valid && e_advance && !clearing_ff;
   assign e_update  = e_fire && e_entry_ff.in_range;
   assign clearing  = clearing_ff;

   assign ram_we    = clearing_ff || e_update;
   assign ram_waddr = clearing_ff ? clr_cnt_ff : ADDR_W'(e_entry_ff.bin);
   assign ram_wdata = clearing_ff ? WORD_W'({FLOOR_DB, FLOOR_DB, {HOLD_W{1'b0}}})
                                  : WORD_W'(new_word);

   sbsph_ram #(
      .WIDTH (WORD_W),
      .DEPTH (NUM_BINS)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (q_pop),
      .raddr (ADDR_W'(q_entry.bin)),
      .rdata (ram_rdata)
   );

   // The last update always holds the newest contents of its bin, so it wins over
   // the store read, which may have missed a write made in the same cycle.
   always_comb begin
      if (fwd_valid_ff && (fwd_bin_ff == e_entry_ff.bin)) begin
         old_word = fwd_word_ff;
      end else begin
         old_word = store_word_type'(ram_rdata);
      end
      lvl    = e_entry_ff.level;
      old_sm = old_word.smoothed;
      old_pk = old_word.peak;
   end

   // One-pole blend with the product truncated toward zero.
   always_comb begin
      diff     = {old_sm[LEVEL_W-1], old_sm} - {lvl[LEVEL_W-1], lvl};
      coeff_s  = $signed({1'b0, cfg.coeff});
      prod     = diff * coeff_s;
      adj      = prod + (prod[PROD_W-1] ? $signed(PROD_W'(ROUND_BIAS)) : $signed(PROD_W'(0)));
      shifted  = adj >>> Q_SHIFT;
      sm_blend = lvl + shifted[LEVEL_W-1:0];
      sm_new   = cfg.bypass ? lvl : sm_blend;
   end

   always_comb begin
      sm_ext     = {sm_new[LEVEL_W-1], sm_new};
      pk_dec     = {old_pk[LEVEL_W-1], old_pk}
                 - {{(LEVEL_W+1-DECAY_W){1'b0}}, cfg.decay};
      pk_clamped = (pk_dec < sm_ext) ? sm_new : pk_dec[LEVEL_W-1:0];
      pk_new     = old_pk;
      hc_new     = old_word.hold_count;
      if (!cfg.peak_enable) begin
         pk_new = FLOOR_DB;
      end else if (sm_new > old_pk) begin
         pk_new = sm_new;
         hc_new = cfg.hold;
      end else if (old_word.hold_count != '0) begin
         hc_new = old_word.hold_count - 1'b1;
      end else begin
         pk_new = pk_clamped;
      end
      new_word = '{smoothed: sm_new, peak: pk_new, hold_count: hc_new};
   end

   assign out_sm = e_entry_ff.in_range ? sm_new : lvl;
   assign out_pk = e_entry_ff.in_range ? pk_new : FLOOR_DB;

   always_comb begin
      clearing_in  = clearing_ff && (clr_cnt_ff != LAST_ADDR);
      clr_cnt_in   = clearing_ff ? clr_cnt_ff + 1'b1 : clr_cnt_ff;
      e_valid_in   = e_advance ? q_pop : e_valid_ff;
      fwd_valid_in = fwd_valid_ff || e_update;
      if (e_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff  <= 1'b1;
         clr_cnt_ff   <= '0;
         e_valid_ff   <= 1'b0;
         fwd_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clearing_ff  <= clearing_in;
         clr_cnt_ff   <= clr_cnt_in;
         e_valid_ff   <= e_valid_in;
         fwd_valid_ff <= fwd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         e_entry_ff <= q_entry;
      end
      if (e_update) begin
         fwd_bin_ff  <= e_entry_ff.bin;
         fwd_word_ff <= new_word;
      end
      if (e_fire) begin
         rsp_bin_ff <= e_entry_ff.bin;
         rsp_sm_ff  <= out_sm;
         rsp_pk_ff  <= out_pk;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_bin     = rsp_bin_ff;
   assign rsp_smoothed_db = rsp_sm_ff;
   assign rsp_peak_db     = rsp_pk_ff;

   `SBSPH_ASSERT_SAME(a_blend_between, clock, reset, e_valid_ff && e_entry_ff.in_range && !cfg.bypass, (sm_new >= lvl && sm_new <= old_sm) || (sm_new <= lvl && sm_new >= old_sm), "smoothed level left the span between old and new level")
   `SBSPH_ASSERT_SAME(a_peak_above_smoothed, clock, reset, e_update && cfg.peak_enable, pk_new >= sm_new, "peak fell below the smoothed level")
   `SBSPH_ASSERT_NEXT(a_clear_once, clock, reset, !clearing_ff, !clearing_ff, "store clearing restarted outside reset")
   `SBSPH_ASSERT_SAME(a_idle_while_clearing, clock, reset, clearing_ff, !e_valid_ff && !rsp_valid_ff && !q_pop, "request in flight during store clearing")

endmodule

// ===== hdl/spectrum_bin_smooth_peak_hold_unit.sv =====
`timescale 1ns / 1ps
// Channel    Direction  Handshake                     Payload
// req        in         req_valid / req_ready         req_bin_index, req_level_db
// rsp        out        rsp_valid / rsp_ready         rsp_out_bin, rsp_smoothed_db, rsp_peak_db
// csr        in/out     psel, penable, pwrite, pready paddr, pwdata, prdata
//
// One request is accepted per cycle while req_ready is high and passes the queue, the
// execute stage and the response register. The execute stage sets the rate; it completes
// each read-modify-write (one blend multiply, then the peak update), forwarding the last update.
// After reset the block sweeps its store, one bin a cycle, over all NUM_BINS (512) bins with
// req_ready low; configuration writes are taken during the sweep.
// When rsp_ready stays low, up to six requests are held before req_ready drops: four in
// the queue, one in execute and one in the response register.

module spectrum_bin_smooth_peak_hold_unit
   import sbsph_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [BIN_W-1:0]          req_bin_index,
   input  logic signed [LEVEL_W-1:0] req_level_db,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [BIN_W-1:0]          rsp_out_bin,
   output logic signed [LEVEL_W-1:0] rsp_smoothed_db,
   output logic signed [LEVEL_W-1:0] rsp_peak_db,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_W-1:0]     paddr,
   input  logic [CSR_DATA_W-1:0]     pwdata,
   output logic [CSR_DATA_W-1:0]     prdata,
   output logic                      pready
);

   config_type      cfg;
   logic            clearing;
   logic            q_valid;
   logic            q_pop;
   queue_entry_type q_entry;

   // The register block also derives the blend coefficient and the bypass flag from the registered
   // smoothing factor and registers them in turn before the datapath sees them.
   sbsph_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // The front end takes requests, flags bins past the end of the store and queues them.
   sbsph_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_bin_index (req_bin_index),
      .req_level_db  (req_level_db),
      .clearing      (clearing),
      .q_valid       (q_valid),
      .q_entry       (q_entry),
      .q_pop         (q_pop)
   );

   // The back end reads the bin's stored state, updates it and holds the response.
   sbsph_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .q_valid         (q_valid),
      .q_entry         (q_entry),
      .q_pop           (q_pop),
      .clearing        (clearing),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_bin     (rsp_out_bin),
      .rsp_smoothed_db (rsp_smoothed_db),
      .rsp_peak_db     (rsp_peak_db)
   );

endmodule
